>>> hw/rtl/tsrp_pkg.sv
// Shared types, character codes and conversion constants for the sensor record parser.
package tsrp_pkg;

  // Record kinds, in the order of the result code
  typedef enum logic [3:0] {
    KIND_TEMP,
    KIND_PRESSURE,
    KIND_HUMIDITY,
    KIND_ALTITUDE,
    KIND_WEATHER,
    KIND_RAIN,
    KIND_WIND_DIR,
    KIND_LIGHT,
    KIND_SPEED,
    KIND_BATTERY
  } kind_e;

  // Conversion path taken by a finished record
  typedef enum logic [1:0] {
    CONV_PASS,
    CONV_TEMP,
    CONV_LIGHT,
    CONV_SPEED
  } conv_mode_e;

  // Configuration register indexes
  localparam logic [1:0] CFG_TEMP_UNIT     = 2'd0;
  localparam logic [1:0] CFG_PRESSURE_UNIT = 2'd1;
  localparam logic [1:0] CFG_SPEED_UNIT    = 2'd2;

  // Speed unit codes
  localparam logic [1:0] SPEED_KNOTS = 2'd0;
  localparam logic [1:0] SPEED_KMH   = 2'd1;
  localparam logic [1:0] SPEED_MPS   = 2'd2;

  // ASCII codes
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_T     = 8'h54;
  localparam logic [7:0] CHAR_P     = 8'h50;
  localparam logic [7:0] CHAR_H     = 8'h48;
  localparam logic [7:0] CHAR_A     = 8'h41;
  localparam logic [7:0] CHAR_W     = 8'h57;
  localparam logic [7:0] CHAR_R     = 8'h52;
  localparam logic [7:0] CHAR_D     = 8'h44;
  localparam logic [7:0] CHAR_L     = 8'h4C;
  localparam logic [7:0] CHAR_V     = 8'h56;
  localparam logic [7:0] CHAR_B     = 8'h42;

  // Shared multiplier operand widths
  localparam int MagW  = 19;
  localparam int FactW = 22;
  localparam int ProdW = MagW + FactW;

  // Reciprocals for the constant divisions and the Q16 speed factors
  localparam logic [FactW-1:0] RECIP_DIV5  = 22'd3355444;  // ceil(2^24 / 5)
  localparam logic [FactW-1:0] RECIP_DIV10 = 22'd52429;    // ceil(2^19 / 10)
  localparam logic [FactW-1:0] Q16_KMH     = 22'd121373;   // 1.852 in Q16
  localparam logic [FactW-1:0] Q16_MPS     = 22'd33711;    // 0.5144 in Q16
  localparam int DIV5_SHIFT  = 24;
  localparam int DIV10_SHIFT = 19;
  localparam int Q16_SHIFT   = 16;

  localparam logic [31:0] TEMP_OFFSET  = 32'd320;
  localparam logic [7:0]  LIGHT_OFFSET = 8'd67;

  // Configuration registers
  typedef struct packed {
    logic       temp_unit;
    logic       pressure_unit;
    logic [1:0] speed_unit;
  } cfg_t;

  // Finished record handed to the conversion pipeline
  typedef struct packed {
    kind_e       kind;
    logic [31:0] raw;
  } rec_t;

  // Kind letter decode result
  typedef struct packed {
    logic  hit;
    kind_e kind;
  } letter_t;

  function automatic letter_t letter_decode(logic [7:0] b);
    letter_t r;
    r.hit  = 1'b1;
    r.kind = KIND_TEMP;
    unique case (b)
      CHAR_T: r.kind = KIND_TEMP;
      CHAR_P: r.kind = KIND_PRESSURE;
      CHAR_H: r.kind = KIND_HUMIDITY;
      CHAR_A: r.kind = KIND_ALTITUDE;
      CHAR_W: r.kind = KIND_WEATHER;
      CHAR_R: r.kind = KIND_RAIN;
      CHAR_D: r.kind = KIND_WIND_DIR;
      CHAR_L: r.kind = KIND_LIGHT;
      CHAR_V: r.kind = KIND_SPEED;
      CHAR_B: r.kind = KIND_BATTERY;
      default: r.hit = 1'b0;
    endcase
    return r;
  endfunction

endpackage

>>> hw/rtl/tagged_sensor_record_parser.sv
// Top level of the tagged sensor record parser: byte parser, config registers, conversion.
//
//   channel | signals                                   | direction
//   --------+-------------------------------------------+----------
//   in      | in_valid_i, in_stall_o, rx_byte_i         | byte items in
//   out     | out_valid_o, out_stall_i, record_kind_o,  | record items out
//           | record_value_o                            |
//   cfg     | cfg_we_i, cfg_index_i, cfg_data_i         | register writes
//
// One byte item is taken every cycle unless in_stall_o is high. A carriage return that
// closes a record gives its result through the parse register, operand stage, shared
// multiplier stage, then the result register. Reset clears the parse state, the unit
// registers and all stage valid bits. A stalled result holds the whole pipeline, so
// in_stall_o is high exactly while a result waits under out_stall_i.
module tagged_sensor_record_parser import tsrp_pkg::*; #(
  parameter int MAX_CHARS = 9
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [3:0]  record_kind_o,
  output logic [31:0] record_value_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [1:0]  cfg_data_i
);

  localparam int CntW = $clog2(MAX_CHARS + 1);
  localparam logic [CntW-1:0] CntMax = CntW'(MAX_CHARS);

  cfg_t            cfg_q;
  logic            adv;
  logic            in_acc;
  letter_t         letter;
  logic [3:0]      digit;
  logic            is_digit;

  logic            open_q, open_d;
  kind_e           kind_q, kind_d;
  logic [31:0]     acc_q, acc_d;
  logic            neg_q, neg_d;
  logic            stop_q, stop_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  logic            rec_valid;
  rec_t            rec_d;
  logic            a_valid_q;
  rec_t            a_rec_q;

  // Hold everything while a result waits
  assign adv        = !(out_valid_o && out_stall_i);
  assign in_stall_o = !adv;
  assign in_acc     = in_valid_i && adv;

  // Write unit registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_TEMP_UNIT:     cfg_q.temp_unit     <= cfg_data_i[0];
        CFG_PRESSURE_UNIT: cfg_q.pressure_unit <= cfg_data_i[0];
        CFG_SPEED_UNIT:    cfg_q.speed_unit    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Parse one byte item: open, accumulate or close a record
  always_comb begin
    letter    = letter_decode(rx_byte_i);
    digit     = rx_byte_i[3:0] - CHAR_ZERO[3:0];
    is_digit  = (rx_byte_i >= CHAR_ZERO) && (rx_byte_i <= CHAR_NINE);
    open_d    = open_q;
    kind_d    = kind_q;
    acc_d     = acc_q;
    neg_d     = neg_q;
    stop_d    = stop_q;
    cnt_d     = cnt_q;
    rec_valid = 1'b0;
    rec_d.kind = kind_q;
    rec_d.raw  = neg_q ? (32'd0 - acc_q) : acc_q;
    if (in_acc) begin
      if (letter.hit) begin
        open_d = 1'b1;
        kind_d = letter.kind;
        acc_d  = '0;
        neg_d  = 1'b0;
        stop_d = 1'b0;
        cnt_d  = '0;
      end else if (open_q) begin
        if (rx_byte_i == CHAR_CR) begin
          rec_valid = 1'b1;
          open_d = 1'b0;
          acc_d  = '0;
          neg_d  = 1'b0;
          stop_d = 1'b0;
          cnt_d  = '0;
        end else if (cnt_q < CntMax) begin
          if (cnt_q == '0 && (rx_byte_i == CHAR_MINUS || rx_byte_i == CHAR_PLUS)) begin
            neg_d = (rx_byte_i == CHAR_MINUS);
          end else if (is_digit && !stop_q) begin
            acc_d = (acc_q << 3) + (acc_q << 1) + {28'd0, digit};
          end else begin
            stop_d = 1'b1;
          end
          cnt_d = cnt_q + 1'b1;
        end
      end
    end
  end

  // Parse state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q <= 1'b0;
      kind_q <= KIND_TEMP;
      acc_q  <= '0;
      neg_q  <= 1'b0;
      stop_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      open_q <= open_d;
      kind_q <= kind_d;
      acc_q  <= acc_d;
      neg_q  <= neg_d;
      stop_q <= stop_d;
      cnt_q  <= cnt_d;
    end
  end

  // Register the closed record
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (adv) begin
      a_valid_q <= rec_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      a_rec_q <= rec_d;
    end
  end

  tsrp_convert u_convert (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv),
    .cfg_i       (cfg_q),
    .rec_valid_i (a_valid_q),
    .rec_i       (a_rec_q),
    .out_valid_o (out_valid_o),
    .out_kind_o  (record_kind_o),
    .out_value_o (record_value_o)
  );

endmodule

>>> hw/rtl/tsrp_convert.sv
// Unit conversion pipeline: operand stage, shared multiplier stage, result register.
module tsrp_convert import tsrp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        adv_i,
  input  cfg_t        cfg_i,
  input  logic        rec_valid_i,
  input  rec_t        rec_i,
  output logic        out_valid_o,
  output logic [3:0]  out_kind_o,
  output logic [31:0] out_value_o
);

  // Operand stage signals
  logic [31:0]      sext16;
  logic [20:0]      temp_x;
  logic [20:0]      temp_abs;
  logic [16:0]      spd_t;
  logic [16:0]      spd_abs;
  logic [13:0]      light_m;
  logic [31:0]      pass_d;
  conv_mode_e       mode_d;
  logic             neg_d;
  logic [MagW-1:0]  mag_d;
  logic [FactW-1:0] fact_d;

  logic             b_valid_q;
  kind_e            b_kind_q;
  conv_mode_e       b_mode_q;
  logic             b_neg_q;
  logic [MagW-1:0]  b_mag_q;
  logic [FactW-1:0] b_fact_q;
  logic [31:0]      b_pass_q;

  logic             c_valid_q;
  kind_e            c_kind_q;
  conv_mode_e       c_mode_q;
  logic             c_neg_q;
  logic [ProdW-1:0] c_prod_q;
  logic [31:0]      c_pass_q;

  logic             o_valid_q;
  kind_e            o_kind_q;
  logic [31:0]      o_value_q;
  logic [31:0]      value_d;

  // Final stage signals
  logic [ProdW-1:0] sh_temp;
  logic [ProdW-1:0] sh_light;
  logic [ProdW-1:0] sh_speed;
  logic [31:0]      q_temp;
  logic [31:0]      q_speed;
  logic [31:0]      s_temp;
  logic [31:0]      s_speed;
  logic [7:0]       light_r;

  // Pick conversion path, pass-through value and multiplier operands
  always_comb begin
    sext16   = {{16{rec_i.raw[15]}}, rec_i.raw[15:0]};
    temp_x   = ({{5{rec_i.raw[15]}}, rec_i.raw[15:0]} << 3)
             + {{5{rec_i.raw[15]}}, rec_i.raw[15:0]};
    temp_abs = temp_x[20] ? (21'd0 - temp_x) : temp_x;
    spd_t    = {rec_i.raw[15], rec_i.raw[15:0]};
    spd_abs  = rec_i.raw[15] ? (17'd0 - spd_t) : spd_t;
    light_m  = {rec_i.raw[7:0], 6'd0} - {6'd0, rec_i.raw[7:0]};

    pass_d = sext16;
    mode_d = CONV_PASS;
    neg_d  = 1'b0;
    mag_d  = '0;
    fact_d = RECIP_DIV5;
    unique case (rec_i.kind)
      KIND_TEMP: begin
        if (cfg_i.temp_unit) begin
          mode_d = CONV_TEMP;
          neg_d  = temp_x[20];
          mag_d  = temp_abs[MagW-1:0];
          fact_d = RECIP_DIV5;
        end
      end
      KIND_PRESSURE: begin
        pass_d = cfg_i.pressure_unit ? ((rec_i.raw << 3) + (rec_i.raw << 1)) : rec_i.raw;
      end
      KIND_WEATHER, KIND_BATTERY: begin
        pass_d = {{24{rec_i.raw[7]}}, rec_i.raw[7:0]};
      end
      KIND_LIGHT: begin
        mode_d = CONV_LIGHT;
        mag_d  = {5'd0, light_m};
        fact_d = RECIP_DIV10;
      end
      KIND_SPEED: begin
        if (cfg_i.speed_unit == SPEED_KMH || cfg_i.speed_unit == SPEED_MPS) begin
          mode_d = CONV_SPEED;
          neg_d  = rec_i.raw[15];
          mag_d  = {2'd0, spd_abs};
          fact_d = (cfg_i.speed_unit == SPEED_KMH) ? Q16_KMH : Q16_MPS;
        end
      end
      default: pass_d = sext16;
    endcase
  end

  // Advance valid bits of all stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
      o_valid_q <= 1'b0;
    end else if (adv_i) begin
      b_valid_q <= rec_valid_i;
      c_valid_q <= b_valid_q;
      o_valid_q <= c_valid_q;
    end
  end

  // Operand stage payload
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      b_kind_q <= rec_i.kind;
      b_mode_q <= mode_d;
      b_neg_q  <= neg_d;
      b_mag_q  <= mag_d;
      b_fact_q <= fact_d;
      b_pass_q <= pass_d;
    end
  end

  // Product stage: one shared multiplier
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      c_kind_q <= b_kind_q;
      c_mode_q <= b_mode_q;
      c_neg_q  <= b_neg_q;
      c_prod_q <= {{FactW{1'b0}}, b_mag_q} * {{MagW{1'b0}}, b_fact_q};
      c_pass_q <= b_pass_q;
    end
  end

  // Scale down, restore sign, add offsets and truncate for the converted kinds; others pass through
  always_comb begin
    sh_temp  = c_prod_q >> DIV5_SHIFT;
    sh_light = c_prod_q >> DIV10_SHIFT;
    sh_speed = c_prod_q >> Q16_SHIFT;
    q_temp   = {15'd0, sh_temp[16:0]};
    q_speed  = {15'd0, sh_speed[16:0]};
    s_temp   = (c_neg_q ? (32'd0 - q_temp) : q_temp) + TEMP_OFFSET;
    s_speed  = c_neg_q ? (32'd0 - q_speed) : q_speed;
    light_r  = sh_light[7:0] + LIGHT_OFFSET;
    unique case (c_mode_q)
      CONV_TEMP:  value_d = {{16{s_temp[15]}}, s_temp[15:0]};
      CONV_LIGHT: value_d = {24'd0, light_r};
      CONV_SPEED: value_d = {{16{s_speed[15]}}, s_speed[15:0]};
      default:    value_d = c_pass_q;
    endcase
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      o_kind_q  <= c_kind_q;
      o_value_q <= value_d;
    end
  end

  assign out_valid_o = o_valid_q;
  assign out_kind_o  = o_kind_q;
  assign out_value_o = o_value_q;

endmodule
